### rtl/point_splat_zbuffer_render_defines.svh
// Assertion macros shared by the RTL.
`ifndef POINT_SPLAT_ZBUFFER_RENDER_DEFINES_SVH
`define POINT_SPLAT_ZBUFFER_RENDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PSZ_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PSZ_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/psz_pkg.sv
`default_nettype none
package psz_pkg;
  localparam int DEF_FRAME_WIDTH      = 960;
  localparam int DEF_FRAME_HEIGHT     = 540;
  localparam int DEF_SUBSAMPLE_STRIDE = 20;

  // screen coordinates stay below 4096
  localparam int COORD_W = 12;
  // camera-space coordinate in Q.8 after the axis dot product
  localparam int C8_W = 37;
  // positive depth magnitude
  localparam int Z8_W = 36;

  localparam logic [23:0] BG_COLOR    = 24'h503080;
  localparam logic [31:0] FAR_DEPTH   = 32'hFFFF_FFFF;
  localparam logic [31:0] FOCAL_RESET = 32'd35434332;

  // frame word: color in the upper bits, depth in the lower
  localparam int MEM_W = 56;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_DRAW  = 2'd1,
    FN_READ  = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    CFG_CAMERA_X   = 4'd0,
    CFG_CAMERA_Y   = 4'd1,
    CFG_CAMERA_Z   = 4'd2,
    CFG_SIDE_AXIS  = 4'd3,
    CFG_UP_AXIS    = 4'd4,
    CFG_VIEW_AXIS  = 4'd5,
    CFG_FOCAL      = 4'd6,
    CFG_DRAW_ALL   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic [COORD_W-1:0] coord;
  } proj_res_t;
endpackage
`default_nettype wire

### rtl/point_splat_zbuffer_render.sv
`default_nettype none
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------------------
// in       start & !busy          in_func, in_point_x/y/z, in_point_color,
//                                 in_pixel_index
// out      out_valid (1 cycle)    out_pixel_color, out_pixel_depth,
//                                 out_point_written
// cfg      cfg_valid & cfg_ready  cfg_index, cfg_data (ready always high)
//
// Work: a drawn point passes the dot-product multiplier (nine products) and
//   the projection divider (one bit a cycle, col then row); a clear writes
//   every pixel through the single write port of the frame memory.
// Reset: a clearing pass fills all FRAME_WIDTH*FRAME_HEIGHT words of the frame
//   memory; busy stays high until it ends. No result word follows it.
// Stalls: one item at a time; the receiver cannot stall, every result word is
//   shown for exactly one cycle.
`include "point_splat_zbuffer_render_defines.svh"
module point_splat_zbuffer_render import psz_pkg::*; #(
  parameter int FRAME_WIDTH      = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT     = DEF_FRAME_HEIGHT,
  parameter int SUBSAMPLE_STRIDE = DEF_SUBSAMPLE_STRIDE
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [23:0]        in_point_color,
  input  logic [18:0]        in_pixel_index,
  // results
  output logic               out_valid,
  output logic [23:0]        out_pixel_color,
  output logic [31:0]        out_pixel_depth,
  output logic               out_point_written,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [47:0]        cfg_data
);
  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int MAXE   = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int QB     = $clog2(MAXE);
  localparam int PW     = $clog2(SUBSAMPLE_STRIDE + 1);

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DOT   = 10'b0000000100,
    S_ZCHK  = 10'b0000001000,
    S_PCOL  = 10'b0000010000,
    S_PROW  = 10'b0000100000,
    S_ADDR  = 10'b0001000000,
    S_RD    = 10'b0010000000,
    S_WR    = 10'b0100000000,
    S_RDPIX = 10'b1000000000
  } state_t;

  // configuration registers
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [47:0]        side_r, up_r, view_r;
  logic [31:0]        focal_r;
  logic               draw_all_r;

  state_t                  state_r;
  logic [AW-1:0]           clr_cnt_r;
  logic                    clr_item_r;
  logic [PW-1:0]           phase_r;
  logic signed [32:0]      dx_r, dy_r, dz_r;
  logic [23:0]             color_r;
  logic [1:0]              k_axis_r, k_comp_r;
  logic signed [50:0]      acc_r;
  logic signed [C8_W-1:0]  x8_r, y8_r, z8_r;
  logic [COORD_W-1:0]      col_r, row_r;
  logic [AW-1:0]           addr_r;
  logic [31:0]             depth_r;
  logic                    rd_oob_r;
  logic                    out_valid_r;
  logic [23:0]             out_color_r;
  logic [31:0]             out_depth_r;
  logic                    out_written_r;

  // dot-product datapath: one 16 x 33 product a cycle
  logic [47:0]        axis_word;
  logic signed [15:0] comp;
  logic signed [32:0] dsel;
  logic signed [48:0] prod;
  logic signed [50:0] sum;
  logic               take;
  logic [PW:0]        ph_inc;
  logic [31:0]        idx32;
  logic               z_pos;

  // frame memory port
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic [MEM_W-1:0] mem_rd_data;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [MEM_W-1:0] mem_wr_data;
  logic             nearer;

  // projection unit
  logic                   prj_start;
  logic signed [C8_W-1:0] prj_c8;
  logic [COORD_W:0]       prj_ext;
  proj_res_t              prj_res;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_pixel_color   = out_color_r;
  assign out_pixel_depth   = out_depth_r;
  assign out_point_written = out_written_r;

  always_comb begin
    case (k_axis_r)
      2'd0:    axis_word = side_r;
      2'd1:    axis_word = up_r;
      default: axis_word = view_r;
    endcase
    case (k_comp_r)
      2'd0: begin
        comp = axis_word[15:0];
        dsel = dx_r;
      end
      2'd1: begin
        comp = axis_word[31:16];
        dsel = dy_r;
      end
      default: begin
        comp = axis_word[47:32];
        dsel = dz_r;
      end
    endcase
  end

  assign prod   = comp * dsel;
  assign sum    = acc_r + 51'(prod);
  assign take   = draw_all_r || (phase_r == '0);
  assign ph_inc = (PW + 1)'(phase_r) + 1'b1;
  assign idx32  = 32'(in_pixel_index);
  assign z_pos  = !z8_r[C8_W-1] && (z8_r != '0);
  assign nearer = mem_rd_data[31:0] > depth_r;

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = addr_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = {color_r, depth_r};
    case (state_r)
      S_IDLE: begin
        mem_rd_en   = start && (in_func == FN_READ);
        mem_rd_addr = idx32[AW-1:0];
      end
      S_RD: begin
        mem_rd_en = 1'b1;
      end
      S_CLR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_r;
        mem_wr_data = {BG_COLOR, FAR_DEPTH};
      end
      S_WR: begin
        mem_wr_en = nearer;
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase
  end

  // column first from S_ZCHK, row back to back from S_PCOL
  assign prj_start = ((state_r == S_ZCHK) && z_pos) ||
                     ((state_r == S_PCOL) && prj_res.done && prj_res.hit);
  assign prj_c8    = (state_r == S_ZCHK) ? x8_r : y8_r;
  assign prj_ext   = (state_r == S_ZCHK) ? (COORD_W + 1)'(FRAME_WIDTH)
                                         : (COORD_W + 1)'(FRAME_HEIGHT);

  psz_frame_mem #(
    .DEPTH (PIXELS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  psz_proj #(
    .QB (QB)
  ) u_proj (
    .clk   (clk),
    .rst_n (rst_n),
    .start (prj_start),
    .c8    (prj_c8),
    .z8    (z8_r[Z8_W-1:0]),
    .ext   (prj_ext),
    .focal (focal_r),
    .res   (prj_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r    <= '0;
      cam_y_r    <= '0;
      cam_z_r    <= '0;
      side_r     <= '0;
      up_r       <= '0;
      view_r     <= '0;
      focal_r    <= FOCAL_RESET;
      draw_all_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAMERA_X:  cam_x_r    <= cfg_data[31:0];
        CFG_CAMERA_Y:  cam_y_r    <= cfg_data[31:0];
        CFG_CAMERA_Z:  cam_z_r    <= cfg_data[31:0];
        CFG_SIDE_AXIS: side_r     <= cfg_data;
        CFG_UP_AXIS:   up_r       <= cfg_data;
        CFG_VIEW_AXIS: view_r     <= cfg_data;
        CFG_FOCAL:     focal_r    <= cfg_data[31:0];
        CFG_DRAW_ALL:  draw_all_r <= cfg_data[0];
        default:       draw_all_r <= draw_all_r;
      endcase
    end
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r   <= 1'b0;
      out_color_r   <= '0;
      out_depth_r   <= '0;
      out_written_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          if (clr_cnt_r == AW'(PIXELS - 1)) begin
            out_valid_r <= clr_item_r;
            clr_item_r  <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            case (func_t'(in_func))
              FN_CLEAR: begin
                clr_cnt_r  <= '0;
                clr_item_r <= 1'b1;
                phase_r    <= '0;
                state_r    <= S_CLR;
              end
              FN_DRAW: begin
                phase_r <= (ph_inc >= (PW + 1)'(SUBSAMPLE_STRIDE)) ? '0 : PW'(ph_inc);
                if (take) begin
                  dx_r     <= 33'(in_point_x) - 33'(cam_x_r);
                  dy_r     <= 33'(in_point_y) - 33'(cam_y_r);
                  dz_r     <= 33'(in_point_z) - 33'(cam_z_r);
                  color_r  <= in_point_color;
                  acc_r    <= '0;
                  k_axis_r <= 2'd0;
                  k_comp_r <= 2'd0;
                  state_r  <= S_DOT;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              FN_READ: begin
                rd_oob_r <= idx32 >= 32'(PIXELS);
                state_r  <= S_RDPIX;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_DOT: begin
          if (k_comp_r == 2'd2) begin
            // floor division by 2^14 is the arithmetic shift
            case (k_axis_r)
              2'd0:    x8_r <= sum[50:14];
              2'd1:    y8_r <= sum[50:14];
              default: z8_r <= sum[50:14];
            endcase
            acc_r    <= '0;
            k_comp_r <= 2'd0;
            if (k_axis_r == 2'd2) begin
              state_r <= S_ZCHK;
            end else begin
              k_axis_r <= k_axis_r + 1'b1;
            end
          end else begin
            acc_r    <= sum;
            k_comp_r <= k_comp_r + 1'b1;
          end
        end
        S_ZCHK: begin
          // depth saturates at the far value, which never wins the compare
          depth_r <= (z8_r[Z8_W-1:32] != '0) ? FAR_DEPTH : z8_r[31:0];
          if (z_pos) begin
            state_r <= S_PCOL;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_PCOL: begin
          if (prj_res.done) begin
            if (prj_res.hit) begin
              col_r   <= prj_res.coord;
              state_r <= S_PROW;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_PROW: begin
          if (prj_res.done) begin
            if (prj_res.hit) begin
              row_r   <= prj_res.coord;
              state_r <= S_ADDR;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_ADDR: begin
          addr_r  <= AW'(32'(col_r) + 32'(row_r) * 32'(FRAME_WIDTH));
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_WR;
        end
        S_WR: begin
          // read-modify-write of one pixel; nothing else touches the memory here
          out_valid_r   <= 1'b1;
          out_written_r <= nearer;
          state_r       <= S_IDLE;
        end
        S_RDPIX: begin
          out_valid_r <= 1'b1;
          if (!rd_oob_r) begin
            out_color_r <= mem_rd_data[MEM_W-1:32];
            out_depth_r <= mem_rd_data[31:0];
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `PSZ_CHECK_NEXT(a_clear_busy, start && !busy && in_func == FN_CLEAR, busy, "clear not busy")
  `PSZ_CHECK(a_wr_after_rd, state_r == S_WR, $past(state_r) == S_RD, "pixel write without read")
  `PSZ_CHECK(a_prj_wait, prj_res.done, state_r == S_PCOL || state_r == S_PROW, "stray proj done")
  `PSZ_CHECK(a_draw_no_data, out_valid && out_point_written, out_pixel_depth == '0, "draw word data")
endmodule
`default_nettype wire

### rtl/psz_frame_mem.sv
`default_nettype none
module psz_frame_mem import psz_pkg::*; #(
  parameter int DEPTH = DEF_FRAME_WIDTH * DEF_FRAME_HEIGHT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [MEM_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [MEM_W-1:0] wr_data
);
  logic [MEM_W-1:0] mem_r [DEPTH];
  logic [MEM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

### rtl/psz_proj.sv
`default_nettype none
// Perspective projection of one coordinate: q = (2*c*f + (E-1)*z*2^16) / (z*2^17),
// with a split multiply and a restoring divider, one quotient bit a cycle.
module psz_proj import psz_pkg::*; #(
  parameter int QB = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [C8_W-1:0] c8,
  input  logic [Z8_W-1:0]        z8,
  input  logic [COORD_W:0]       ext,
  input  logic [31:0]            focal,
  output proj_res_t              res
);
  localparam int P_W   = C8_W + 32;
  localparam int NW    = P_W + 2;
  localparam int CNT_W = $clog2(QB);
  localparam int HI_W  = C8_W - 32;

  typedef enum logic [6:0] {
    P_IDLE = 7'b0000001,
    P_MLO  = 7'b0000010,
    P_MHI  = 7'b0000100,
    P_NUM  = 7'b0001000,
    P_PRE  = 7'b0010000,
    P_DIV  = 7'b0100000,
    P_FIN  = 7'b1000000
  } pstate_t;

  pstate_t            state_r;
  logic [C8_W-1:0]    mag_r;
  logic               sgn_r;
  logic [Z8_W-1:0]    z_r;
  logic [COORD_W:0]   ext_r;
  logic [P_W-1:0]     t1_r;
  logic [NW-1:0]      t2_r;
  logic [NW-1:0]      num_r;
  logic [NW-1:0]      dsh_r;
  logic [QB-1:0]      q_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic               off_r;

  logic               load;
  logic [QB-1:0]      em1;
  logic [Z8_W+QB-1:0] zp;
  logic [63:0]        lo_prod;
  logic [HI_W+31:0]   hi_prod;
  logic [NW-1:0]      t1x;
  logic [NW-1:0]      dv;
  logic [NW-1:0]      dtop;
  logic               ge;
  logic [COORD_W:0]   ext_m1;

  assign load    = start && (state_r == P_IDLE || state_r == P_FIN);
  assign ext_m1  = ext - 1'b1;
  assign em1     = ext_m1[QB-1:0];
  assign zp      = z8 * em1;
  assign lo_prod = mag_r[31:0] * focal;
  assign hi_prod = mag_r[C8_W-1:32] * focal;
  assign t1x     = NW'({t1_r, 1'b0});
  assign dv      = NW'({z_r, 17'h0});
  assign dtop    = dv << QB;
  assign ge      = num_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
    end else begin
      if (load) begin
        mag_r <= c8[C8_W-1] ? C8_W'(-c8) : C8_W'(c8);
        sgn_r <= c8[C8_W-1];
        z_r   <= z8;
        ext_r <= ext;
        t2_r  <= NW'({zp, 16'h0});
      end
      case (state_r)
        P_IDLE, P_FIN: begin
          state_r <= load ? P_MLO : P_IDLE;
        end
        P_MLO: begin
          t1_r    <= P_W'(lo_prod);
          state_r <= P_MHI;
        end
        P_MHI: begin
          t1_r    <= t1_r + P_W'({hi_prod, 32'h0});
          state_r <= P_NUM;
        end
        P_NUM: begin
          if (!sgn_r) begin
            num_r <= t1x + t2_r;
            neg_r <= 1'b0;
          end else if (t2_r < t1x) begin
            num_r <= t1x - t2_r;
            neg_r <= 1'b1;
          end else begin
            num_r <= t2_r - t1x;
            neg_r <= 1'b0;
          end
          state_r <= P_PRE;
        end
        P_PRE: begin
          q_r <= '0;
          if (neg_r) begin
            // a negative sum truncates to column zero only while below one step
            off_r   <= num_r >= dv;
            state_r <= P_FIN;
          end else if (num_r >= dtop) begin
            off_r   <= 1'b1;
            state_r <= P_FIN;
          end else begin
            off_r   <= 1'b0;
            dsh_r   <= dv << (QB - 1);
            cnt_r   <= CNT_W'(QB - 1);
            state_r <= P_DIV;
          end
        end
        P_DIV: begin
          if (ge) begin
            num_r <= num_r - dsh_r;
          end
          q_r   <= {q_r[QB-2:0], ge};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= P_FIN;
          end
        end
        default: begin
          state_r <= P_IDLE;
        end
      endcase
    end
  end

  assign res.done  = (state_r == P_FIN);
  assign res.hit   = !off_r && (neg_r || ((COORD_W + 1)'(q_r) < ext_r));
  assign res.coord = COORD_W'(q_r);
endmodule
`default_nettype wire
